>>> src/dad_pkg.sv
// ----------------------------------------------------------------------------
// dad_pkg
// Shared types, constants and calendar helpers for the date adder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dad_pkg;

  localparam int unsigned MonthsPerYear = 12;
  localparam int unsigned YearW         = 15;  // internal year counter, wraps on output
  localparam int unsigned RemW          = 16;  // day-of-year plus day count
  localparam int unsigned ProdW         = 27;  // year times reciprocal of 25
  localparam int unsigned Recip25       = 5243; // ceil(2^17 / 25)
  localparam int unsigned Recip25Shift  = 17;

  localparam logic [3:0] MonthJan = 4'd1;
  localparam logic [3:0] MonthFeb = 4'd2;
  localparam logic [3:0] MonthDec = 4'd12;

  localparam logic [8:0] LenLeapYear   = 9'd366;
  localparam logic [8:0] LenCommonYear = 9'd365;
  localparam logic [4:0] LenFebLeap    = 5'd29;
  localparam logic [4:0] LenFebCommon  = 5'd28;

  localparam logic [4:0] MonthLenTab [MonthsPerYear] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef struct packed {
    logic [4:0]  start_day;
    logic [3:0]  start_month;
    logic [13:0] start_year;
    logic [14:0] days_to_add;
  } dad_in_t;

  typedef struct packed {
    logic [4:0]  result_day;
    logic [3:0]  result_month;
    logic [13:0] result_year;
  } dad_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // latch a new transaction
    logic mul;       // year times reciprocal
    logic modulo;    // finish year mod 25
    logic clamp;     // clamp start day, seed remainder
    logic doy_step;  // add one month length to the day of year
    logic add_days;  // add the day count
    logic year_step; // remove one year
    logic mon_init;  // restart the month walk
    logic mon_step;  // remove one month
    logic out_load;  // capture the result
  } dad_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic doy_more;
    logic year_more;
    logic mon_more;
  } dad_sts_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [3:0] idx;
    idx = m - 4'd1;
    if (m == MonthFeb) begin
      month_len = leap ? LenFebLeap : LenFebCommon;
    end else if (idx < 4'(MonthsPerYear)) begin
      month_len = MonthLenTab[idx];
    end else begin
      month_len = MonthLenTab[4'(MonthsPerYear - 1)];
    end
  endfunction

endpackage

>>> src/dad_ctrl.sv
// ----------------------------------------------------------------------------
// dad_ctrl
// Sequencer for the date adder: steps the datapath and owns the handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dad_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  dad_pkg::dad_sts_t sts_i,
  output dad_pkg::dad_cmd_t cmd_o
);
  import dad_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StMul   = 3'd1;
  localparam logic [2:0] StMod   = 3'd2;
  localparam logic [2:0] StClamp = 3'd3;
  localparam logic [2:0] StDoy   = 3'd4;
  localparam logic [2:0] StYear  = 3'd5;
  localparam logic [2:0] StMon   = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StMul;
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StMod;
      end
      StMod: begin
        cmd_o.modulo = 1'b1;
        state_d      = StClamp;
      end
      StClamp: begin
        cmd_o.clamp = 1'b1;
        state_d     = StDoy;
      end
      StDoy: begin
        if (sts_i.doy_more) begin
          cmd_o.doy_step = 1'b1;
        end else begin
          cmd_o.add_days = 1'b1;
          state_d        = StYear;
        end
      end
      StYear: begin
        if (sts_i.year_more) begin
          cmd_o.year_step = 1'b1;
        end else begin
          cmd_o.mon_init = 1'b1;
          state_d        = StMon;
        end
      end
      StMon: begin
        if (sts_i.mon_more) begin
          cmd_o.mon_step = 1'b1;
        end else if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> src/dad_dp.sv
// ----------------------------------------------------------------------------
// dad_dp
// Datapath: day-of-year accumulation, year and month walks, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dad_dp (
  input  logic              clk_i,
  input  dad_pkg::dad_in_t  in_data_i,
  input  dad_pkg::dad_cmd_t cmd_i,
  output dad_pkg::dad_sts_t sts_o,
  output dad_pkg::dad_out_t out_data_o
);
  import dad_pkg::*;

  logic [YearW-1:0] year_q;
  logic [4:0]       r25_q;     // year mod 25, kept in step with year_q
  logic [ProdW-1:0] prod_q;
  logic [3:0]       month_q;   // clamped start month
  logic [3:0]       m_q;
  logic [4:0]       day_q;
  logic [14:0]      add_q;
  logic [RemW-1:0]  rem_q;
  dad_out_t         out_q;

  logic             leap;
  logic [4:0]       mlen_cur, mlen_tgt, day_clamped;
  logic [8:0]       ylen;
  logic [9:0]       quot;
  logic [YearW-1:0] quot25;
  logic [3:0]       month_clamped;

  // leap: divisible by 4 and not by 100, or by 400 (= by 16 and by 25)
  assign leap     = (year_q[1:0] == 2'b00) && ((r25_q != 5'd0) || (year_q[3:0] == 4'd0));
  assign ylen     = leap ? LenLeapYear : LenCommonYear;
  assign mlen_cur = month_len(m_q, leap);
  assign mlen_tgt = month_len(month_q, leap);

  assign quot   = prod_q[Recip25Shift +: 10];
  assign quot25 = {1'b0, quot, 4'b0} + {2'b0, quot, 3'b0} + {5'b0, quot};

  always_comb begin
    month_clamped = in_data_i.start_month;
    if (month_clamped < MonthJan) month_clamped = MonthJan;
    if (month_clamped > MonthDec) month_clamped = MonthDec;
    day_clamped = day_q;
    if (day_clamped == 5'd0)     day_clamped = 5'd1;
    if (day_clamped > mlen_tgt)  day_clamped = mlen_tgt;
  end

  assign sts_o.doy_more  = (m_q < month_q);
  assign sts_o.year_more = (rem_q > RemW'(ylen));
  assign sts_o.mon_more  = (m_q < MonthDec) && (rem_q > RemW'(mlen_cur));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      year_q  <= {1'b0, in_data_i.start_year};
      month_q <= month_clamped;
      day_q   <= in_data_i.start_day;
      add_q   <= in_data_i.days_to_add;
    end
    if (cmd_i.mul) begin
      prod_q <= ProdW'(year_q) * ProdW'(Recip25);
    end
    if (cmd_i.modulo) begin
      r25_q <= 5'(year_q - quot25);
    end
    if (cmd_i.clamp) begin
      rem_q <= RemW'(day_clamped);
      m_q   <= MonthJan;
    end
    if (cmd_i.doy_step) begin
      rem_q <= rem_q + RemW'(mlen_cur);
      m_q   <= m_q + 4'd1;
    end
    if (cmd_i.add_days) begin
      rem_q <= rem_q + RemW'(add_q);
    end
    if (cmd_i.year_step) begin
      rem_q  <= rem_q - RemW'(ylen);
      year_q <= year_q + YearW'(1);
      r25_q  <= (r25_q == 5'd24) ? 5'd0 : r25_q + 5'd1;
    end
    if (cmd_i.mon_init) begin
      m_q <= MonthJan;
    end
    if (cmd_i.mon_step) begin
      rem_q <= rem_q - RemW'(mlen_cur);
      m_q   <= m_q + 4'd1;
    end
    if (cmd_i.out_load) begin
      out_q.result_day   <= rem_q[4:0];
      out_q.result_month <= m_q;
      out_q.result_year  <= year_q[13:0];
    end
  end

  assign out_data_o = out_q;

endmodule

>>> src/date_add_days_top.sv
// ----------------------------------------------------------------------------
// date_add_days_top
// Gregorian date plus a day count, one result per input transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) takes a start date
//   and a day count; output channel (out_valid_o / out_ready_i / out_data_o)
//   returns the date that many days later. Out-of-range day or month values
//   are clamped; a day of year equal to the year length stays in that year.
//   Sequence: accept and latch, multiply, mod 25, clamp, month steps up to
//   the start month, add count, year steps removing whole years, month
//   walk restart, month steps through the final year, result load; the
//   result load waits while the output register holds a stalled result, and
//   out_valid_o is registered from it. The year walk sets the worst case.
//   One transaction is in flight at a time; the next is accepted at the
//   earliest in the cycle after the result load.
//   in_ready_o is high whenever the sequencer is idle, including while a
//   finished result still waits in the output register.
//   If the receiver stalls, the next result waits in the sequencer until the
//   output register drains; nothing is dropped or overwritten.
//   Reset (rst_ni low, asynchronous) returns the sequencer to idle and clears
//   out_valid_o; any transaction in flight is discarded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module date_add_days_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dad_pkg::dad_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dad_pkg::dad_out_t out_data_o
);
  import dad_pkg::*;

  // command and status between sequencer and datapath
  dad_cmd_t cmd;
  dad_sts_t sts;

  // sequencer: state machine plus output valid flag
  dad_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: remainder, year counter with mod-25 tracker, month walk
  dad_dp u_dp (
    .clk_i      (clk_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

>>> src/dad_checker.sv
// ----------------------------------------------------------------------------
// dad_checker
// Port-level checks on the date adder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dad_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input dad_pkg::dad_out_t out_data_o
);
  import dad_pkg::*;

  // one transaction at a time: no new acceptance straight after one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted on consecutive cycles");

  // result valid does not rise while the multiply and mod 25 steps run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !$rose(out_valid_o) ##1 !$rose(out_valid_o))
    else $error("result appeared too soon after acceptance");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed or dropped");

  // month and day of a result are in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.result_day != 5'd0) &&
                    (out_data_o.result_month >= MonthJan) &&
                    (out_data_o.result_month <= MonthDec))
    else $error("result date out of range");

endmodule

bind date_add_days_top dad_checker u_dad_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
